// ===== design/pceg_pkg.sv =====
// shared types and constants for the pad change event generator
package pceg_pkg;

  localparam int FIELD_AXES    = 6;
  localparam int FIELD_BUTTONS = 10;
  localparam int AXIS_SLOTS    = 2 * FIELD_AXES;
  localparam int EV_SLOTS      = AXIS_SLOTS + FIELD_BUTTONS;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [1:0]  AXIS_LOW  = 2'd0;
  localparam logic [1:0]  AXIS_MID  = 2'd1;
  localparam logic [1:0]  AXIS_HIGH = 2'd2;
  localparam logic [11:0] ALL_MID   = 12'h555;
  localparam logic [7:0]  COUNT_MAX = 8'd255;

  localparam logic SRC_AXIS   = 1'b0;
  localparam logic SRC_BUTTON = 1'b1;

  typedef enum logic [1:0] {
    KIND_POLL  = 2'd0,
    KIND_OPEN  = 2'd1,
    KIND_CLOSE = 2'd2
  } kind_t;

  // one poll sample that produces at least one event
  typedef struct packed {
    logic [3:0]               pad;
    logic [FIELD_AXES-1:0]    rel_mask;
    logic [FIELD_AXES-1:0]    rel_high;
    logic [FIELD_AXES-1:0]    prs_mask;
    logic [FIELD_AXES-1:0]    prs_high;
    logic [FIELD_BUTTONS-1:0] btn_diff;
    logic [FIELD_BUTTONS-1:0] btn_val;
  } job_t;

  function automatic logic [1:0] norm_pos(input logic [1:0] code);
    norm_pos = (code == 2'd3) ? AXIS_MID : code;
  endfunction

endpackage

// ===== design/pceg_front.sv =====
// front end: per-pad state, open/close handling and change classification
module pceg_front import pceg_pkg::*; #(
  parameter int NUM_PADS    = 16,
  parameter int NUM_AXES    = 6,
  parameter int NUM_BUTTONS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [1:0]  kind,
  input  logic [3:0]  pad_index,
  input  logic [11:0] axis_positions,
  input  logic [9:0]  button_mask,
  output logic        job_push,
  output job_t        job
);

  localparam int PAD_W    = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
  localparam int AXES_EFF = (NUM_AXES < FIELD_AXES) ? NUM_AXES : FIELD_AXES;
  localparam int BTN_EFF  = (NUM_BUTTONS < FIELD_BUTTONS) ? NUM_BUTTONS : FIELD_BUTTONS;

  logic [7:0]  open_count    [NUM_PADS];
  logic [11:0] prior_axes    [NUM_PADS];
  logic [9:0]  prior_buttons [NUM_PADS];

  logic [PAD_W-1:0] idx;
  logic             pad_ok;
  kind_t            k;
  logic [7:0]       cnt;
  logic [11:0]      old_axes;
  logic [9:0]       old_btn;
  logic [9:0]       bmask;
  logic [1:0]       now_pos;
  logic [1:0]       was_pos;

  logic             wr_en;
  logic [7:0]       open_count_next;
  logic [11:0]      prior_axes_next;
  logic [9:0]       prior_buttons_next;
  logic             has_events;

  assign idx      = pad_index[PAD_W-1:0];
  assign pad_ok   = ({1'b0, pad_index} < 5'(NUM_PADS));
  assign k        = kind_t'(kind);
  assign cnt      = open_count[idx];
  assign old_axes = prior_axes[idx];
  assign old_btn  = prior_buttons[idx];

  always_comb begin
    bmask = '0;
    for (int b = 0; b < FIELD_BUTTONS; b++) begin
      if (b < BTN_EFF) bmask[b] = 1'b1;
    end
  end

  // change classification for a poll sample
  always_comb begin
    job             = '0;
    job.pad         = pad_index;
    prior_axes_next = old_axes;
    now_pos         = AXIS_MID;
    was_pos         = AXIS_MID;
    for (int a = 0; a < FIELD_AXES; a++) begin
      now_pos = norm_pos(axis_positions[2*a +: 2]);
      was_pos = norm_pos(old_axes[2*a +: 2]);
      if (a < AXES_EFF) begin
        prior_axes_next[2*a +: 2] = now_pos;
        if (now_pos != was_pos) begin
          job.rel_mask[a] = (was_pos != AXIS_MID);
          job.rel_high[a] = (was_pos == AXIS_HIGH);
          job.prs_mask[a] = (now_pos != AXIS_MID);
          job.prs_high[a] = (now_pos == AXIS_HIGH);
        end
      end
    end
    job.btn_val  = button_mask & bmask;
    job.btn_diff = (button_mask & bmask) ^ old_btn;
  end

  assign has_events = (|job.rel_mask) || (|job.prs_mask) || (|job.btn_diff);

  always_comb begin
    wr_en              = 1'b0;
    job_push           = 1'b0;
    open_count_next    = cnt;
    prior_buttons_next = old_btn;
    if (accept && pad_ok) begin
      unique case (k)
        KIND_OPEN: begin
          wr_en = 1'b1;
          if (cnt != COUNT_MAX) open_count_next = cnt + 8'd1;
        end
        KIND_CLOSE: begin
          wr_en = 1'b1;
          if (cnt != 8'd0) open_count_next = cnt - 8'd1;
        end
        KIND_POLL: begin
          if (cnt != 8'd0) begin
            wr_en              = 1'b1;
            prior_buttons_next = job.btn_val;
            job_push           = has_events;
          end
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PADS; p++) begin
        open_count[p]    <= '0;
        prior_axes[p]    <= ALL_MID;
        prior_buttons[p] <= '0;
      end
    end else if (wr_en) begin
      open_count[idx] <= open_count_next;
      if (k == KIND_POLL) begin
        prior_axes[idx]    <= prior_axes_next;
        prior_buttons[idx] <= prior_buttons_next;
      end else if (k == KIND_OPEN && cnt == 8'd0) begin
        prior_axes[idx]    <= ALL_MID;
        prior_buttons[idx] <= '0;
      end
    end
  end

endmodule

// ===== design/pceg_queue.sv =====
// short job queue between front and back end
module pceg_queue import pceg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign pop_data = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

endmodule

// ===== design/pceg_back.sv =====
// back end: walks one job's pending events, one per cycle while pop does not stall, into the output register
module pceg_back import pceg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_pop,
  input  logic       pop,
  output logic       empty,
  output logic [3:0] event_pad,
  output logic       event_source,
  output logic [3:0] event_index,
  output logic       axis_high_side,
  output logic       is_press,
  output logic       last_event
);

  logic                     busy;
  logic [3:0]               pad;
  logic [EV_SLOTS-1:0]      pend;
  logic [FIELD_AXES-1:0]    rel_high;
  logic [FIELD_AXES-1:0]    prs_high;
  logic [FIELD_BUTTONS-1:0] btn_val;
  logic                     out_valid;

  logic [EV_SLOTS-1:0]      job_pend;
  logic [4:0]               sel;
  logic [EV_SLOTS-1:0]      sel_bit;
  logic [EV_SLOTS-1:0]      pend_next;
  logic                     advance;
  logic [2:0]               ax;
  logic [3:0]               btn;
  logic                     ev_src;
  logic [3:0]               ev_idx;
  logic                     ev_high;
  logic                     ev_press;

  // slot order: release then press per axis, then buttons
  always_comb begin
    for (int a = 0; a < FIELD_AXES; a++) begin
      job_pend[2*a]     = job.rel_mask[a];
      job_pend[2*a + 1] = job.prs_mask[a];
    end
    job_pend[EV_SLOTS-1:AXIS_SLOTS] = job.btn_diff;
  end

  always_comb begin
    sel = '0;
    for (int i = EV_SLOTS - 1; i >= 0; i--) begin
      if (pend[i]) sel = 5'(i);
    end
  end

  assign sel_bit   = EV_SLOTS'(1) << sel;
  assign pend_next = pend & ~sel_bit;
  assign ax        = sel[3:1];
  assign btn       = 4'(sel - 5'(AXIS_SLOTS));

  always_comb begin
    if (sel < 5'(AXIS_SLOTS)) begin
      ev_src   = SRC_AXIS;
      ev_idx   = {1'b0, ax};
      ev_press = sel[0];
      ev_high  = sel[0] ? prs_high[ax] : rel_high[ax];
    end else begin
      ev_src   = SRC_BUTTON;
      ev_idx   = btn;
      ev_press = btn_val[btn];
      ev_high  = 1'b0;
    end
  end

  assign advance = !out_valid || pop;
  assign job_pop = !busy && job_valid;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (advance && busy) begin
      event_pad      <= pad;
      event_source   <= ev_src;
      event_index    <= ev_idx;
      axis_high_side <= ev_high;
      is_press       <= ev_press;
      last_event     <= (pend_next == '0);
    end
    if (job_pop) begin
      pad      <= job.pad;
      rel_high <= job.rel_high;
      prs_high <= job.prs_high;
      btn_val  <= job.btn_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      pend      <= '0;
    end else begin
      if (advance) out_valid <= busy;
      if (job_pop) begin
        busy <= 1'b1;
        pend <= job_pend;
      end else if (advance && busy) begin
        pend <= pend_next;
        if (pend_next == '0) busy <= 1'b0;
      end
    end
  end

endmodule

// ===== design/pad_change_event_generator.sv =====
// top level of the pad change event generator
//
//   channel   | handshake          | payload
//   ----------+--------------------+-----------------------------------------------
//   input     | push / full        | kind, pad_index, axis_positions, button_mask
//   result    | pop / empty        | event_pad, event_source, event_index,
//             |                    | axis_high_side, is_press, last_event
//
// open, close and polls that change nothing finish in the cycle they are taken
// a poll with n events is first loaded into the back end, then gives one
// event per cycle while pop does not stall; the back end's event walk sets the rate
// the two-entry job queue lets the front take items while the back end works
// synchronous reset sets every pad closed, axes mid and buttons released
// stalls on pop hold the current event; full rises only when the queue fills
module pad_change_event_generator import pceg_pkg::*; #(
  parameter int NUM_PADS    = 16,
  parameter int NUM_AXES    = 6,
  parameter int NUM_BUTTONS = 10
) (
  input  logic        clk,
  input  logic        rst,
  // input side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [3:0]  pad_index,
  input  logic [11:0] axis_positions,
  input  logic [9:0]  button_mask,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  event_pad,
  output logic        event_source,
  output logic [3:0]  event_index,
  output logic        axis_high_side,
  output logic        is_press,
  output logic        last_event
);

  logic accept;     // an item taken this cycle
  logic job_push;   // poll sample with at least one event
  job_t front_job;
  logic q_valid;
  logic q_pop;
  job_t q_job;

  assign accept = push && !full;

  // front end: state lookup, open/close, change masks
  pceg_front #(
    .NUM_PADS    (NUM_PADS),
    .NUM_AXES    (NUM_AXES),
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .kind           (kind),
    .pad_index      (pad_index),
    .axis_positions (axis_positions),
    .button_mask    (button_mask),
    .job_push       (job_push),
    .job            (front_job)
  );

  // decoupling queue; full backs up the input side
  pceg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (front_job),
    .full      (full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_job)
  );

  // back end: event walk and output register
  pceg_back u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (q_valid),
    .job            (q_job),
    .job_pop        (q_pop),
    .pop            (pop),
    .empty          (empty),
    .event_pad      (event_pad),
    .event_source   (event_source),
    .event_index    (event_index),
    .axis_high_side (axis_high_side),
    .is_press       (is_press),
    .last_event     (last_event)
  );

endmodule

// ===== design/pceg_checker.sv =====
// port-level checks for the pad change event generator, bound to the top level
module pceg_checker import pceg_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [3:0] event_pad,
  input logic       event_source,
  input logic [3:0] event_index,
  input logic       axis_high_side,
  input logic       last_event
);

  // a held event keeps its pad and index
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(event_pad) && $stable(event_index))
    else $error("held event changed");

  // button events never carry a direction
  a_btn_dir: assert property (@(posedge clk) disable iff (rst)
    !empty && event_source == SRC_BUTTON |-> !axis_high_side)
    else $error("button event with direction");

  // index within the axis or button field
  a_index: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (event_source == SRC_AXIS && event_index < 4'(FIELD_AXES)) ||
               (event_source == SRC_BUTTON && event_index < 4'(FIELD_BUTTONS)))
    else $error("event index out of range");

  // a sample's events come out back to back from the same pad
  a_burst: assert property (@(posedge clk) disable iff (rst)
    !empty && pop && !last_event |=> !empty && event_pad == $past(event_pad))
    else $error("event burst broken");

endmodule

bind pad_change_event_generator pceg_checker u_pceg_checker (
  .clk            (clk),
  .rst            (rst),
  .empty          (empty),
  .pop            (pop),
  .event_pad      (event_pad),
  .event_source   (event_source),
  .event_index    (event_index),
  .axis_high_side (axis_high_side),
  .last_event     (last_event)
);

// ===== dv/pad_change_event_generator_test.sv =====
// self-checking testbench for the pad change event generator
module pad_change_event_generator_test;
  import pceg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PADS    = 16;
  localparam int NUM_AXES    = 6;
  localparam int NUM_BUTTONS = 10;

  // only the axes and buttons that fit in the item fields ever give events
  localparam int AXIS_LIM = (NUM_AXES < FIELD_AXES) ? NUM_AXES : FIELD_AXES;
  localparam int BTN_LIM  = (NUM_BUTTONS < FIELD_BUTTONS) ? NUM_BUTTONS : FIELD_BUTTONS;

  localparam int RANDOM_ITEMS = 106;
  localparam int DRAIN_CYCLES = 40;
  // worst case is about 22 events per item, each held off by a random pop wait, ~130 items
  localparam int CYCLE_LIMIT  = 100_000;

  // kind code that the block has no use for
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic [3:0] pad;
    logic       src;
    logic [3:0] idx;
    logic       high;
    logic       press;
    logic       last;
  } pad_event_t;

  // how a row of the directed table is checked
  typedef enum logic [1:0] {
    BY_MODEL,   // expected events come from the predictor
    NO_EVENT,   // the item must give nothing
    ONE_EVENT   // the item gives exactly the event typed in the row
  } row_check_t;

  typedef struct packed {
    logic [1:0]  kind_code;
    logic [3:0]  pad;
    logic [11:0] axes;
    logic [9:0]  btns;
    row_check_t  check;
    pad_event_t  ev;
  } plan_row_t;

  localparam pad_event_t NO_EV = '0;
  localparam int NUM_ROWS = 24;

  // directed walk: closed pads, the unused kind, extremes of every field,
  // code three as mid, re-open clearing the state, open count above one
  localparam plan_row_t PLAN [NUM_ROWS] = '{
    '{KIND_POLL,  4'd0,  12'hAAA, 10'h3FF, NO_EVENT, NO_EV},  // poll of a closed pad
    '{KIND_CLOSE, 4'd0,  12'h000, 10'h000, NO_EVENT, NO_EV},  // close of a closed pad
    '{KIND_SPARE, 4'd1,  12'hFFF, 10'h3FF, NO_EVENT, NO_EV},  // unused kind
    '{KIND_OPEN,  4'd0,  12'h000, 10'h000, NO_EVENT, NO_EV},
    '{KIND_POLL,  4'd0,  12'h556, 10'h000, ONE_EVENT,
      '{4'd0, SRC_AXIS, 4'd0, 1'b1, 1'b1, 1'b1}},
    '{KIND_POLL,  4'd0,  12'h554, 10'h000, BY_MODEL, NO_EV},  // high to low on axis 0
    '{KIND_POLL,  4'd0,  12'hAAA, 10'h3FF, BY_MODEL, NO_EV},
    '{KIND_POLL,  4'd0,  12'h000, 10'h000, BY_MODEL, NO_EV},  // longest burst
    '{KIND_POLL,  4'd0,  12'hFFF, 10'h2AA, BY_MODEL, NO_EV},  // code three on all axes
    '{KIND_POLL,  4'd0,  12'hFFF, 10'h2AA, NO_EVENT, NO_EV},  // nothing changed
    '{KIND_POLL,  4'd0,  12'h555, 10'h2AA, NO_EVENT, NO_EV},  // three was stored as mid
    '{KIND_POLL,  4'd0,  12'h955, 10'h2AA, ONE_EVENT,
      '{4'd0, SRC_AXIS, 4'd5, 1'b1, 1'b1, 1'b1}},
    '{KIND_OPEN,  4'd15, 12'hFFF, 10'h3FF, NO_EVENT, NO_EV},
    '{KIND_POLL,  4'd15, 12'h555, 10'h200, ONE_EVENT,
      '{4'd15, SRC_BUTTON, 4'd9, 1'b0, 1'b1, 1'b1}},
    '{KIND_CLOSE, 4'd15, 12'h000, 10'h000, NO_EVENT, NO_EV},
    '{KIND_POLL,  4'd15, 12'h555, 10'h000, NO_EVENT, NO_EV},  // closed again
    '{KIND_OPEN,  4'd15, 12'h000, 10'h000, NO_EVENT, NO_EV},  // first open clears buttons
    '{KIND_POLL,  4'd15, 12'h555, 10'h200, ONE_EVENT,
      '{4'd15, SRC_BUTTON, 4'd9, 1'b0, 1'b1, 1'b1}},
    '{KIND_OPEN,  4'd15, 12'h000, 10'h000, NO_EVENT, NO_EV},  // count two
    '{KIND_CLOSE, 4'd15, 12'h000, 10'h000, NO_EVENT, NO_EV},  // still open
    '{KIND_POLL,  4'd15, 12'h555, 10'h000, ONE_EVENT,
      '{4'd15, SRC_BUTTON, 4'd9, 1'b0, 1'b0, 1'b1}},
    '{KIND_OPEN,  4'd8,  12'h000, 10'h000, NO_EVENT, NO_EV},
    '{KIND_POLL,  4'd8,  12'h3FF, 10'h001, BY_MODEL, NO_EV},
    '{KIND_POLL,  4'd0,  12'h556, 10'h155, BY_MODEL, NO_EV}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  kind = '0;
  logic [3:0]  pad_index = '0;
  logic [11:0] axis_positions = '0;
  logic [9:0]  button_mask = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  event_pad;
  logic        event_source;
  logic [3:0]  event_index;
  logic        axis_high_side;
  logic        is_press;
  logic        last_event;

  // predictor state, one entry per pad
  logic [7:0]  open_cnt  [NUM_PADS];
  logic [11:0] axes_seen [NUM_PADS];
  logic [9:0]  btns_seen [NUM_PADS];

  pad_event_t events_due [$];   // events the block still owes, oldest first
  pad_event_t seen_ev, due_ev;

  bit steady = 1'b0;            // both sides run without idling while set
  int pop_wait = 0;
  int errors = 0;
  int items_sent = 0;
  int events_checked = 0;
  int longest_burst = 0;
  int cycle_count = 0;

  pad_change_event_generator #(
    .NUM_PADS    (NUM_PADS),
    .NUM_AXES    (NUM_AXES),
    .NUM_BUTTONS (NUM_BUTTONS)
  ) i_dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .kind           (kind),
    .pad_index      (pad_index),
    .axis_positions (axis_positions),
    .button_mask    (button_mask),
    .empty          (empty),
    .pop            (pop),
    .event_pad      (event_pad),
    .event_source   (event_source),
    .event_index    (event_index),
    .axis_high_side (axis_high_side),
    .is_press       (is_press),
    .last_event     (last_event)
  );

  always #5 clk = ~clk;

  // three-level axis position; the spare code reads as mid
  function automatic logic [1:0] level_of(input logic [1:0] code);
    return (code == 2'd3) ? AXIS_MID : code;
  endfunction

  // update the pad state for one item and list the events it should cause
  task automatic predict_events(input logic [1:0] k, input logic [3:0] p,
                                input logic [11:0] ax, input logic [9:0] bt,
                                output pad_event_t batch [$]);
    logic [1:0]  now, was;
    logic [11:0] new_axes;
    logic [9:0]  keep;
    batch = {};
    if (int'(p) >= NUM_PADS) return;
    case (k)
      KIND_OPEN: begin
        if (open_cnt[p] == 0) begin
          axes_seen[p] = ALL_MID;
          btns_seen[p] = '0;
        end
        if (open_cnt[p] != COUNT_MAX) open_cnt[p] = open_cnt[p] + 8'd1;
      end
      KIND_CLOSE: begin
        if (open_cnt[p] != 0) open_cnt[p] = open_cnt[p] - 8'd1;
      end
      KIND_POLL: begin
        if (open_cnt[p] != 0) begin
          new_axes = axes_seen[p];
          for (int a = 0; a < AXIS_LIM; a++) begin
            now = level_of(ax[2*a +: 2]);
            was = level_of(axes_seen[p][2*a +: 2]);
            if (now != was) begin
              // release the old direction before pressing the new one
              if (was != AXIS_MID)
                batch.push_back('{p, SRC_AXIS, 4'(a), was == AXIS_HIGH, 1'b0, 1'b0});
              if (now != AXIS_MID)
                batch.push_back('{p, SRC_AXIS, 4'(a), now == AXIS_HIGH, 1'b1, 1'b0});
            end
            new_axes[2*a +: 2] = now;
          end
          axes_seen[p] = new_axes;
          keep = '0;
          for (int b = 0; b < BTN_LIM; b++) begin
            keep[b] = 1'b1;
            if (bt[b] != btns_seen[p][b])
              batch.push_back('{p, SRC_BUTTON, 4'(b), 1'b0, bt[b], 1'b0});
          end
          btns_seen[p] = bt & keep;
        end
      end
      default: ;
    endcase
    if (batch.size() != 0) batch[batch.size()-1].last = 1'b1;
  endtask

  // drive one item until taken, then queue what it should produce
  task automatic send_and_track(input logic [1:0] k, input logic [3:0] p,
                                input logic [11:0] ax, input logic [9:0] bt,
                                input row_check_t check, input pad_event_t typed_ev);
    int gap;
    pad_event_t batch [$];
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push           <= 1'b1;
    kind           <= k;
    pad_index      <= p;
    axis_positions <= ax;
    button_mask    <= bt;
    // full is read before the edge updates it
    do @(posedge clk); while (full);
    predict_events(k, p, ax, bt, batch);
    case (check)
      NO_EVENT:  ;
      ONE_EVENT: events_due.push_back(typed_ev);
      default:   foreach (batch[i]) events_due.push_back(batch[i]);
    endcase
    items_sent++;
    if (batch.size() > longest_burst) longest_burst = batch.size();
  endtask

  task automatic report_field(input string name, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    errors++;
  endtask

  // result side: take events at random, compare each with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      pop_wait = 0;
    end else if (pop && !empty) begin
      seen_ev = '{event_pad, event_source, event_index, axis_high_side, is_press,
                  last_event};
      if (events_due.size() == 0) begin
        $display("%0t: event with nothing expected, expected none, got %h",
                 $time, seen_ev);
        errors++;
      end else begin
        due_ev = events_due.pop_front();
        events_checked++;
        if (seen_ev.pad != due_ev.pad)     report_field("event_pad", due_ev.pad, seen_ev.pad);
        if (seen_ev.src != due_ev.src)     report_field("event_source", due_ev.src, seen_ev.src);
        if (seen_ev.idx != due_ev.idx)     report_field("event_index", due_ev.idx, seen_ev.idx);
        if (seen_ev.high != due_ev.high)   report_field("axis_high_side", due_ev.high,
                                                        seen_ev.high);
        if (seen_ev.press != due_ev.press) report_field("is_press", due_ev.press, seen_ev.press);
        if (seen_ev.last != due_ev.last)   report_field("last_event", due_ev.last, seen_ev.last);
      end
      pop_wait = steady ? 0 : $urandom_range(0, 5);
      if (pop_wait != 0) pop <= 1'b0;
    end else if (!pop) begin
      if (pop_wait != 0) pop_wait--;
      if (pop_wait == 0) pop <= 1'b1;
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    pad_event_t  none_ev;
    logic [1:0]  k;
    logic [3:0]  p;
    logic [11:0] ax;
    logic [9:0]  bt;
    int          roll;

    none_ev = '0;
    for (int i = 0; i < NUM_PADS; i++) begin
      open_cnt[i]  = '0;
      axes_seen[i] = ALL_MID;
      btns_seen[i] = '0;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int r = 0; r < NUM_ROWS; r++)
      send_and_track(PLAN[r].kind_code, PLAN[r].pad, PLAN[r].axes, PLAN[r].btns,
                     PLAN[r].check, PLAN[r].ev);

    // hold the sender until the block has handed over everything
    push <= 1'b0;
    do @(posedge clk); while (events_due.size() != 0);

    // random part: mostly polls on a few pads, each poll moving some axes
    // and flipping a few buttons; opens, closes, polls of closed pads and the
    // unused kind are mixed in
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 40 && i < 60);
      if (i == 70) begin
        push <= 1'b0;
        do @(posedge clk); while (events_due.size() != 0);
      end
      roll = $urandom_range(0, 99);
      p = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
      ax = axes_seen[p];
      for (int a = 0; a < FIELD_AXES; a++)
        if ($urandom_range(0, 2) == 0) ax[2*a +: 2] = 2'($urandom_range(0, 3));
      bt = btns_seen[p] ^ 10'($urandom & $urandom);
      if ($urandom_range(0, 6) == 0) bt = 10'($urandom);
      if (roll < 66)      k = KIND_POLL;
      else if (roll < 82) k = KIND_OPEN;
      else if (roll < 90) k = KIND_CLOSE;
      else                k = KIND_SPARE;
      send_and_track(k, p, ax, bt, BY_MODEL, none_ev);
    end
    steady = 1'b0;

    push <= 1'b0;
    do @(posedge clk); while (events_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items (directed table, random mix), %0d events checked",
             items_sent, events_checked);
    $display("longest burst from one item %0d events, %0d mismatches", longest_burst, errors);
    if (errors == 0 && events_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
